// File: design/prv_pkg.sv
// ----------------------------------------------------------------------------
// prv_pkg
// Shared types, constants and helpers for the rrip victim select block.
// ----------------------------------------------------------------------------
package prv_pkg;

    // sizes
    localparam int WAYS_DEFAULT = 8;
    localparam int MAX_WAYS     = 8;
    localparam int WAY_IDX_W    = 3;
    localparam int RRPV_W       = 4;
    localparam int DIST_W       = 7;
    localparam int NREF_W       = DIST_W * MAX_WAYS;
    localparam int REJ_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 16;

    // rrpv after reset: insert value of the reset config (max 3, minus one)
    localparam logic [RRPV_W-1:0] RRPV_RESET = 4'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RRPV_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QBS_ATTEMPTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PT_PROTECT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_MODE    = 2'd3;

    // operation codes
    localparam logic OP_HIT  = 1'b0;
    localparam logic OP_FILL = 1'b1;

    // command into the rrpv bank
    typedef struct packed {
        logic                 wr_en;
        logic [WAY_IDX_W-1:0] wr_idx;
        logic [RRPV_W-1:0]    wr_val;
        logic [MAX_WAYS-1:0]  age_mask;
        logic [WAY_IDX_W-1:0] rd_idx;
    } bank_cmd_t;

    // largest rrpv for the configured width, width saturated to 1..4
    function automatic logic [RRPV_W-1:0] rrpv_max(input logic [2:0] bits);
        logic [RRPV_W-1:0] m;
        case (bits)
            3'd0, 3'd1: m = 4'd1;
            3'd2:       m = 4'd3;
            3'd3:       m = 4'd7;
            default:    m = 4'd15;
        endcase
        return m;
    endfunction

    // allowed rejections, attempts saturated to 1..8
    function automatic logic [REJ_W-1:0] attempt_limit(input logic [3:0] a);
        logic [REJ_W-1:0] l;
        if (a == 4'd0) begin
            l = '0;
        end else if (a > 4'd8) begin
            l = 3'd7;
        end else begin
            l = 3'(a - 4'd1);
        end
        return l;
    endfunction

endpackage

// File: design/prv_rrpv_bank.sv
// ----------------------------------------------------------------------------
// prv_rrpv_bank
// Per-way re-reference values: one write port, one read port and a masked
// aging step that saturates every selected way at the current max.
// ----------------------------------------------------------------------------
module prv_rrpv_bank
    import prv_pkg::*;
#(
    parameter int WAYS = WAYS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bank_cmd_t           cmd,
    input  logic [RRPV_W-1:0]   mx,
    output logic [RRPV_W-1:0]   rd_val,
    output logic [MAX_WAYS-1:0] at_max_mask
);

    localparam int WAY_W = $clog2(WAYS);

    logic [RRPV_W-1:0] rrpv_reg  [WAYS];
    logic [RRPV_W-1:0] rrpv_next [WAYS];

    // write wins over aging on the same way
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            rrpv_next[w] = rrpv_reg[w];
            if (cmd.wr_en && cmd.wr_idx == WAY_IDX_W'(w)) begin
                rrpv_next[w] = cmd.wr_val;
            end else if (cmd.age_mask[w] && rrpv_reg[w] < mx) begin
                rrpv_next[w] = rrpv_reg[w] + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < WAYS; w++) begin
                rrpv_reg[w] <= RRPV_RESET;
            end
        end else begin
            rrpv_reg <= rrpv_next;
        end
    end

    // read port
    assign rd_val = rrpv_reg[cmd.rd_idx[WAY_W-1:0]];

    // ways at or above max count as at max
    always_comb begin
        at_max_mask = '0;
        for (int w = 0; w < WAYS; w++) begin
            at_max_mask[w] = (rrpv_reg[w] >= mx);
        end
    end

endmodule

// File: design/popt_rrip_victim_select.sv
// ----------------------------------------------------------------------------
// popt_rrip_victim_select
// Replacement policy for one cache set: srrip with query-based rejection and
// a predictive mode using property flags and next-reference distances.
// ----------------------------------------------------------------------------
// One item is in flight at a time; s_tready is high only while the sequencer
// is idle. A hit, a fill into an invalid way and a predictive fill that finds
// a non-property way pass from the start state to the finish state, which
// loads the result register; the block is ready again in the cycle in which
// the result becomes valid. An srrip fill probes one way per cycle from the
// rotating pointer and ages all ways after each pass, taking the way at the
// pointer after the last aging pass. A predictive fill among property ways
// first finds the largest distance, then ages the ways at that distance
// until one of them is at max and selects it. A stalled receiver holds the
// block in the finish state until the result register is free. The result
// register holds the last result until taken, and configuration writes are
// always accepted; write them only while the block is idle.
// ----------------------------------------------------------------------------
module popt_rrip_victim_select
    import prv_pkg::*;
#(
    parameter int WAYS = WAYS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // hit_way[2:0], valid_mask[10:3], page_table_mask[18:11],
    // lower_level_mask[26:19], property_mask[34:27], next_ref_packed[90:35],
    // insert_is_page_table[91], zero pad[95:92]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic                  s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // victim_way[2:0], qbs_rejects[5:3], prior_rrpv[9:6], zero pad[15:10]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int WAY_W = $clog2(WAYS);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_AGE   = 3'd3;
    localparam logic [2:0] ST_DMAX  = 3'd4;
    localparam logic [2:0] ST_PSEL  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // configuration
    logic [2:0] rrpv_bits_reg;
    logic [3:0] qbs_attempts_reg;
    logic       pt_protect_reg;
    logic       pred_mode_reg;

    // captured request
    logic                 op_reg;
    logic [2:0]           hw_reg;
    logic [WAYS-1:0]      valid_reg;
    logic [WAYS-1:0]      pt_reg;
    logic [WAYS-1:0]      ll_reg;
    logic [WAYS-1:0]      prop_reg;
    logic [NREF_W-1:0]    nref_reg;
    logic                 ins_pt_reg;

    // sequencer
    logic [2:0]           state_reg,   state_next;
    logic [WAY_W-1:0]     ptr_reg,     ptr_next;
    logic [WAY_W-1:0]     probe_reg,   probe_next;
    logic [WAY_W-1:0]     idx_reg,     idx_next;
    logic [RRPV_W-1:0]    round_reg,   round_next;
    logic [REJ_W-1:0]     attempt_reg, attempt_next;
    logic [DIST_W-1:0]    dmax_reg,    dmax_next;
    logic [2:0]           res_way_reg, res_way_next;
    logic [REJ_W-1:0]     res_rej_reg, res_rej_next;
    logic [RRPV_W-1:0]    res_prior_reg, res_prior_next;

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // datapath
    logic [RRPV_W-1:0]    mx;
    logic [RRPV_W-1:0]    ins_val;
    logic [REJ_W-1:0]     limit;
    bank_cmd_t            cmd;
    logic [RRPV_W-1:0]    rd_val;
    logic [MAX_WAYS-1:0]  at_max_mask;
    logic [DIST_W-1:0]    nref_dist [WAYS];
    logic [MAX_WAYS-1:0]  cand_mask;
    logic                 inv_found, np_found, sel_found;
    logic [WAY_W-1:0]     inv_idx, np_idx, sel_idx;
    logic [WAY_W-1:0]     ptr_inc;
    logic                 hw_ok;
    logic                 reject;
    logic                 s_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rrpv_bits_reg    <= 3'd2;
            qbs_attempts_reg <= 4'd1;
            pt_protect_reg   <= 1'b0;
            pred_mode_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RRPV_BITS:    rrpv_bits_reg    <= cfg_data[2:0];
                REG_QBS_ATTEMPTS: qbs_attempts_reg <= cfg_data;
                REG_PT_PROTECT:   pt_protect_reg   <= cfg_data[0];
                REG_PRED_MODE:    pred_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // capture request on transfer
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg     <= s_tuser;
            hw_reg     <= s_tdata[2:0];
            valid_reg  <= s_tdata[3 +: WAYS];
            pt_reg     <= s_tdata[11 +: WAYS];
            ll_reg     <= s_tdata[19 +: WAYS];
            prop_reg   <= s_tdata[27 +: WAYS];
            nref_reg   <= s_tdata[35 +: NREF_W];
            ins_pt_reg <= s_tdata[91];
        end
    end

    assign mx      = rrpv_max(rrpv_bits_reg);
    assign ins_val = mx - 4'd1;
    assign limit   = attempt_limit(qbs_attempts_reg);
    assign hw_ok   = ({1'b0, hw_reg} < 4'(WAYS));
    assign ptr_inc = (ptr_reg == WAY_W'(WAYS - 1)) ? '0 : ptr_reg + 1'b1;

    for (genvar w = 0; w < WAYS; w++) begin : g_dist
        assign nref_dist[w] = nref_reg[DIST_W*w +: DIST_W];
    end

    // priority picks: first invalid, first non-property, first candidate at max
    always_comb begin
        inv_found = 1'b0;
        inv_idx   = '0;
        np_found  = 1'b0;
        np_idx    = '0;
        sel_found = 1'b0;
        sel_idx   = '0;
        cand_mask = '0;
        for (int w = 0; w < WAYS; w++) begin
            cand_mask[w] = (nref_dist[w] == dmax_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!valid_reg[w]) begin
                inv_found = 1'b1;
                inv_idx   = WAY_W'(w);
            end
            if (!prop_reg[w]) begin
                np_found = 1'b1;
                np_idx   = WAY_W'(w);
            end
            if (cand_mask[w] && at_max_mask[w]) begin
                sel_found = 1'b1;
                sel_idx   = WAY_W'(w);
            end
        end
    end

    // query-based rejection of the way at the pointer
    assign reject = (attempt_reg < limit) &&
                    (ll_reg[ptr_reg] || (pt_reg[ptr_reg] && pt_protect_reg));

    // sequencer
    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        probe_next     = probe_reg;
        idx_next       = idx_reg;
        round_next     = round_reg;
        attempt_next   = attempt_reg;
        dmax_next      = dmax_reg;
        res_way_next   = res_way_reg;
        res_rej_next   = res_rej_reg;
        res_prior_next = res_prior_reg;
        cmd.wr_en      = 1'b0;
        cmd.wr_idx     = 3'(ptr_reg);
        cmd.wr_val     = ins_val;
        cmd.age_mask   = '0;
        cmd.rd_idx     = (state_reg == ST_START) ? hw_reg : 3'(ptr_reg);

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_START;
                end
            end

            // hit, invalid-way fill, non-property predictive fill or dispatch to a search
            ST_START: begin
                res_rej_next   = '0;
                res_prior_next = '0;
                if (op_reg == OP_HIT) begin
                    res_way_next = hw_reg;
                    if (hw_ok) begin
                        res_prior_next = rd_val;
                        cmd.wr_en      = 1'b1;
                        cmd.wr_idx     = hw_reg;
                        cmd.wr_val     = '0;
                    end
                    state_next = ST_FIN;
                end else if (inv_found) begin
                    res_way_next = 3'(inv_idx);
                    cmd.wr_en    = 1'b1;
                    cmd.wr_idx   = 3'(inv_idx);
                    cmd.wr_val   = (pt_protect_reg && ins_pt_reg) ? '0 : ins_val;
                    state_next   = ST_FIN;
                end else if (!pred_mode_reg) begin
                    probe_next   = '0;
                    round_next   = '0;
                    attempt_next = '0;
                    state_next   = ST_SCAN;
                end else if (np_found) begin
                    res_way_next = 3'(np_idx);
                    cmd.wr_en    = 1'b1;
                    cmd.wr_idx   = 3'(np_idx);
                    state_next   = ST_FIN;
                end else begin
                    idx_next   = '0;
                    dmax_next  = '0;
                    state_next = ST_DMAX;
                end
            end

            // one srrip probe per cycle at the pointer
            ST_SCAN: begin
                if (rd_val >= mx && !reject) begin
                    res_way_next = 3'(ptr_reg);
                    res_rej_next = attempt_reg;
                    cmd.wr_en    = 1'b1;
                    ptr_next     = ptr_inc;
                    state_next   = ST_FIN;
                end else begin
                    if (rd_val >= mx) begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_val   = '0;
                        attempt_next = attempt_reg + 1'b1;
                    end else begin
                        ptr_next = ptr_inc;
                    end
                    if (probe_reg == WAY_W'(WAYS - 1)) begin
                        state_next = ST_AGE;
                    end else begin
                        probe_next = probe_reg + 1'b1;
                    end
                end
            end

            // age all ways; after the last round take the way at the pointer
            ST_AGE: begin
                cmd.age_mask = {MAX_WAYS{1'b1}};
                if (round_reg == mx) begin
                    res_way_next = 3'(ptr_reg);
                    res_rej_next = attempt_reg;
                    cmd.wr_en    = 1'b1;
                    ptr_next     = ptr_inc;
                    state_next   = ST_FIN;
                end else begin
                    round_next = round_reg + 4'd1;
                    probe_next = '0;
                    state_next = ST_SCAN;
                end
            end

            // largest next-reference distance, one way per cycle
            ST_DMAX: begin
                if (nref_dist[idx_reg] > dmax_reg) begin
                    dmax_next = nref_dist[idx_reg];
                end
                if (idx_reg == WAY_W'(WAYS - 1)) begin
                    state_next = ST_PSEL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // lowest farthest way at max, else age the farthest ways
            ST_PSEL: begin
                if (sel_found) begin
                    res_way_next = 3'(sel_idx);
                    cmd.wr_en    = 1'b1;
                    cmd.wr_idx   = 3'(sel_idx);
                    state_next   = ST_FIN;
                end else begin
                    cmd.age_mask = cand_mask;
                end
            end

            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg     <= probe_next;
        idx_reg       <= idx_next;
        round_reg     <= round_next;
        attempt_reg   <= attempt_next;
        dmax_reg      <= dmax_next;
        res_way_reg   <= res_way_next;
        res_rej_reg   <= res_rej_next;
        res_prior_reg <= res_prior_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'b0, res_prior_reg, res_rej_reg, res_way_reg};
        end
    end

    // re-reference value bank
    prv_rrpv_bank #(
        .WAYS (WAYS)
    ) u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .mx          (mx),
        .rd_val      (rd_val),
        .at_max_mask (at_max_mask)
    );

    // a transfer always starts the sequencer
    a_fire_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_START)
        else $error("request transfer did not start the sequencer");

    // a finished item is loaded into the result register and the block goes idle
    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && (!m_tvalid_reg || m_tready))
            |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished item not delivered to result register");

    // probe counter stays inside the set
    a_probe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> {1'b0, probe_reg} <= (WAY_W + 1)'(WAYS - 1))
        else $error("probe counter beyond last way");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rrip victim select block. A directed table of
// hits, fills and register settings comes first, then random traffic under
// several register settings and idle/stall patterns. Each result is checked
// against a fixed pick or a behavioral model of the set's rrpv and pointer.
// ----------------------------------------------------------------------------
module tb_top
    import prv_pkg::*;
();

    // one request item
    typedef struct packed {
        logic        op;
        logic [2:0]  hit_way;
        logic [7:0]  valid_mask;
        logic [7:0]  pt_mask;
        logic [7:0]  lower_mask;
        logic [7:0]  prop_mask;
        logic [55:0] next_ref;
        logic        insert_pt;
    } access_t;

    // one result item
    typedef struct packed {
        logic [2:0] way;
        logic [2:0] rejects;
        logic [3:0] prior;
    } pick_t;

    // full register setting
    typedef struct packed {
        logic [2:0] bits;
        logic [3:0] attempts;
        logic       pt_protect;
        logic       predictive;
    } policy_t;

    typedef enum logic {ROW_REG, ROW_XFER} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        policy_t   policy;
        access_t   acc;
        logic      typed;
        pick_t     pick;
    } dir_row_t;

    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 88;
    localparam int REPORT_MAX  = 10;
    localparam int TAIL_CYCLES = 200;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // model state and registers
    logic [3:0] rrpv_st [0:7];
    logic [2:0] probe_ptr;
    policy_t    cur_policy;

    pick_t    pending_picks [$];
    dir_row_t dir_rows [$];
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       err_count      = 0;

    popt_rrip_victim_select u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // largest rrpv for the current width, width saturated to 1..4
    function automatic logic [3:0] rrpv_ceiling();
        case (cur_policy.bits)
            3'd0, 3'd1: return 4'd1;
            3'd2:       return 4'd3;
            3'd3:       return 4'd7;
            default:    return 4'd15;
        endcase
    endfunction

    // rejections allowed in one fill
    function automatic int reject_budget();
        if (cur_policy.attempts == 4'd0) return 0;
        if (cur_policy.attempts > 4'd8) return 7;
        return int'(cur_policy.attempts) - 1;
    endfunction

    function automatic access_t mk_access(logic op, logic [2:0] hw, logic [7:0] vm,
                                          logic [7:0] pm, logic [7:0] lm, logic [7:0] qm,
                                          logic [55:0] nr, logic ip);
        access_t a;
        a.op = op; a.hit_way = hw; a.valid_mask = vm; a.pt_mask = pm;
        a.lower_mask = lm; a.prop_mask = qm; a.next_ref = nr; a.insert_pt = ip;
        return a;
    endfunction

    // result of one access, updating the rrpv table and pointer
    task automatic resolve_access(input access_t a, output pick_t p);
        logic [3:0] mx;
        int         limit, attempt, victim, dmax, w, rnd, probe, guard, idx;
        int         far_dist [0:7];
        bit         found;
        mx      = rrpv_ceiling();
        limit   = reject_budget();
        attempt = 0;
        victim  = 0;
        found   = 1'b0;
        p       = '0;
        if (a.op == OP_HIT) begin
            p.way   = a.hit_way;
            p.prior = rrpv_st[a.hit_way];
            rrpv_st[a.hit_way] = 4'd0;
        end else begin
            // first invalid way
            for (w = 0; w < 8 && !found; w++) begin
                if (!a.valid_mask[w]) begin
                    rrpv_st[w] = (a.insert_pt && cur_policy.pt_protect) ? 4'd0 : mx - 4'd1;
                    victim = w;
                    found  = 1'b1;
                end
            end
            if (!found && !cur_policy.predictive) begin
                // srrip probing with query-based rejection
                for (rnd = 0; rnd <= int'(mx) && !found; rnd++) begin
                    for (probe = 0; probe < 8 && !found; probe++) begin
                        idx = int'(probe_ptr);
                        if (rrpv_st[idx] >= mx) begin
                            if (attempt < limit && (a.lower_mask[idx] ||
                                (a.pt_mask[idx] && cur_policy.pt_protect))) begin
                                rrpv_st[idx] = 4'd0;
                                attempt++;
                            end else begin
                                probe_ptr = probe_ptr + 3'd1;
                                victim = idx;
                                found  = 1'b1;
                            end
                        end else begin
                            probe_ptr = probe_ptr + 3'd1;
                        end
                    end
                    if (!found) begin
                        for (w = 0; w < 8; w++)
                            if (rrpv_st[w] < mx) rrpv_st[w] = rrpv_st[w] + 4'd1;
                    end
                end
                // search exhausted: take the way at the pointer
                if (!found) begin
                    victim = int'(probe_ptr);
                    probe_ptr = probe_ptr + 3'd1;
                end
                rrpv_st[victim] = mx - 4'd1;
            end else if (!found) begin
                // first non-property way, else farthest next reference
                for (w = 0; w < 8 && !found; w++) begin
                    if (!a.prop_mask[w]) begin
                        victim = w;
                        found  = 1'b1;
                    end
                end
                dmax = 0;
                for (w = 0; w < 8; w++) begin
                    far_dist[w] = int'(a.next_ref[7*w +: 7]);
                    if (far_dist[w] > dmax) dmax = far_dist[w];
                end
                for (guard = 0; guard <= 16 && !found; guard++) begin
                    for (w = 0; w < 8 && !found; w++) begin
                        if (far_dist[w] == dmax && rrpv_st[w] >= mx) begin
                            victim = w;
                            found  = 1'b1;
                        end
                    end
                    if (!found) begin
                        for (w = 0; w < 8; w++)
                            if (far_dist[w] == dmax && rrpv_st[w] < mx)
                                rrpv_st[w] = rrpv_st[w] + 4'd1;
                    end
                end
                rrpv_st[victim] = mx - 4'd1;
            end
            p.way     = 3'(victim);
            p.rejects = 3'(attempt);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // write all four registers, then release the channel
    task automatic set_regs(input policy_t pol);
        write_reg(REG_RRPV_BITS, {1'b0, pol.bits});
        write_reg(REG_QBS_ATTEMPTS, pol.attempts);
        write_reg(REG_PT_PROTECT, {3'b0, pol.pt_protect});
        write_reg(REG_PRED_MODE, {3'b0, pol.predictive});
        cfg_valid  <= 1'b0;
        cur_policy = pol;
    endtask

    // send one request, record its result on transfer
    task automatic send_access(input access_t a, input logic typed, input pick_t fixed);
        pick_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= a.op;
        s_tdata  <= {4'b0, a.insert_pt, a.next_ref, a.prop_mask, a.lower_mask,
                     a.pt_mask, a.valid_mask, a.hit_way};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        resolve_access(a, p);
        pending_picks.push_back(typed ? fixed : p);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic access_t rand_access();
        access_t a;
        int      sel;
        a.op      = ($urandom_range(99) < 35) ? OP_HIT : OP_FILL;
        a.hit_way = 3'($urandom_range(7));
        sel = $urandom_range(9);
        a.valid_mask = (sel < 7) ? 8'hff : 8'($urandom);
        sel = $urandom_range(3);
        a.lower_mask = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : 8'($urandom);
        a.pt_mask    = ($urandom_range(4) == 0) ? 8'hff : 8'($urandom);
        a.prop_mask  = ($urandom_range(3) != 0) ? 8'hff : 8'($urandom);
        if ($urandom_range(4) == 0) begin
            a.next_ref = 56'({$urandom, $urandom});
        end else begin
            for (int w = 0; w < 8; w++)
                a.next_ref[7*w +: 7] = ($urandom_range(1) == 0) ? 7'h7f
                                                                 : 7'($urandom_range(127));
        end
        a.insert_pt = 1'($urandom_range(1));
        return a;
    endfunction

    function automatic void add_reg(input policy_t pol);
        dir_row_t r;
        r = '0;
        r.kind   = ROW_REG;
        r.policy = pol;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_xfer(input access_t a, input logic typed, input pick_t p);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_XFER;
        r.acc   = a;
        r.typed = typed;
        r.pick  = p;
        dir_rows.push_back(r);
    endfunction

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // result check against the oldest pending pick
    always @(posedge aclk) begin
        pick_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.way     = m_tdata[2:0];
            got.rejects = m_tdata[5:3];
            got.prior   = m_tdata[9:6];
            if (pending_picks.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("%0t: unexpected result way %0d rej %0d prior %0d",
                             $realtime, got.way, got.rejects, got.prior);
            end else begin
                want = pending_picks.pop_front();
                if (got.way !== want.way || got.rejects !== want.rejects ||
                    got.prior !== want.prior) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("%0t: mismatch way %0d/%0d rej %0d/%0d prior %0d/%0d",
                                 $realtime, want.way, got.way, want.rejects,
                                 got.rejects, want.prior, got.prior);
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        policy_t    pol;
        logic [55:0] all_far, tie_ref;
        int         send_pct [0:3];
        int         stall_pct [0:3];
        send_pct  = '{0, 61, 0, 22};
        stall_pct = '{0, 0, 61, 22};
        all_far = {8{7'h7f}};
        tie_ref = {7'd5, 7'd127, 7'd9, 7'd0, 7'd127, 7'd3, 7'd64, 7'd1};

        // model after reset
        cur_policy = '{bits: 3'd2, attempts: 4'd1, pt_protect: 1'b0, predictive: 1'b0};
        for (int w = 0; w < 8; w++) rrpv_st[w] = RRPV_RESET;
        probe_ptr = 3'd0;

        // directed: reset setting, hits and fills at the mask extremes
        add_xfer(mk_access(OP_HIT, 3'd0, 8'hff, '0, '0, '0, '0, 1'b0), 1'b1,
                 '{3'd0, 3'd0, 4'd2});
        add_xfer(mk_access(OP_HIT, 3'd7, 8'hff, '0, '0, '0, '0, 1'b0), 1'b1,
                 '{3'd7, 3'd0, 4'd2});
        add_xfer(mk_access(OP_HIT, 3'd0, 8'hff, '0, '0, '0, '0, 1'b0), 1'b1,
                 '{3'd0, 3'd0, 4'd0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'h00, '0, '0, '0, '0, 1'b0), 1'b1,
                 '{3'd0, 3'd0, 4'd0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'h7f, '0, '0, '0, '0, 1'b0), 1'b1,
                 '{3'd7, 3'd0, 4'd0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, '0, '0, '0, 1'b0), 1'b0, '0);
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, 8'hff, '0, '0, 1'b0), 1'b0, '0);
        add_xfer(mk_access(OP_FILL, 3'd7, 8'hff, 8'hff, 8'hff, 8'hff, all_far, 1'b1),
                 1'b0, '0);
        // width below range, rrpv left above max, then an exhausted search
        add_reg('{bits: 3'd0, attempts: 4'd8, pt_protect: 1'b0, predictive: 1'b0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, 8'h00, '0, '0, 1'b0), 1'b0, '0);
        for (int w = 0; w < 8; w++)
            add_xfer(mk_access(OP_HIT, 3'(w), 8'hff, '0, '0, '0, '0, 1'b0), 1'b0, '0);
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, 8'hff, '0, '0, 1'b0), 1'b0, '0);
        // width and attempts above range, predictive selection
        add_reg('{bits: 3'd7, attempts: 4'd15, pt_protect: 1'b1, predictive: 1'b1});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hfe, '0, '0, 8'hff, '0, 1'b1), 1'b1,
                 '{3'd0, 3'd0, 4'd0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, '0, 8'hff, all_far, 1'b0), 1'b0, '0);
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, '0, 8'h7f, '0, 1'b0), 1'b1,
                 '{3'd7, 3'd0, 4'd0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, '0, '0, 8'hff, tie_ref, 1'b0), 1'b0, '0);
        // page-table rejection
        add_reg('{bits: 3'd3, attempts: 4'd4, pt_protect: 1'b1, predictive: 1'b0});
        add_xfer(mk_access(OP_FILL, 3'd0, 8'hff, 8'hff, 8'h00, '0, '0, 1'b0), 1'b0, '0);
        add_xfer(mk_access(OP_HIT, 3'd3, 8'hff, '0, '0, '0, '0, 1'b0), 1'b0, '0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                drain();
                set_regs(dir_rows[i].policy);
            end else begin
                send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].pick);
            end
        end

        // random segments, extremes first
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg)
                0:       pol = '{bits: 3'd1, attempts: 4'd1, pt_protect: 1'b0, predictive: 1'b0};
                1:       pol = '{bits: 3'd4, attempts: 4'd8, pt_protect: 1'b1, predictive: 1'b1};
                2:       pol = '{bits: 3'd0, attempts: 4'd0, pt_protect: 1'b1, predictive: 1'b0};
                3:       pol = '{bits: 3'd7, attempts: 4'd15, pt_protect: 1'b0, predictive: 1'b1};
                default: pol = '{bits: 3'($urandom_range(7)), attempts: 4'($urandom_range(15)),
                                 pt_protect: 1'($urandom_range(1)),
                                 predictive: ($urandom_range(2) == 0)};
            endcase
            send_idle_pct  = send_pct[seg % 4];
            recv_stall_pct = stall_pct[seg % 4];
            set_regs(pol);
            repeat (SEG_ITEMS) send_access(rand_access(), 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        err_count += pending_picks.size();
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
